[rtl/jac_pkg.sv]
package jac_pkg;

    // Width of a mapped position and of the stability counter.
    localparam int POS_BITS   = 7;
    localparam int COUNT_BITS = 7;
    // Quotient bits of the linear map; the quotient never exceeds 98.
    localparam int QUOT_BITS  = 7;
    localparam int QCNT_BITS  = 3;

    localparam logic [POS_BITS-1:0] POS_LOW      = 7'd1;
    localparam logic [POS_BITS-1:0] POS_HIGH     = 7'd99;
    localparam logic [POS_BITS-1:0] POS_CENTRE   = 7'd50;
    localparam logic [POS_BITS-1:0] POS_DIR_LOW  = 7'd25;
    localparam logic [POS_BITS-1:0] POS_DIR_HIGH = 7'd75;

    localparam int                    STABLE_STEP  = 10;
    localparam logic [COUNT_BITS-1:0] STABLE_LIMIT = 7'd100;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_NEG  = 2'd1;
    localparam logic [1:0] DIR_POS  = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_BITS  = 3;
    localparam logic [2:0] REG_X_CENTER    = 3'd0;
    localparam logic [2:0] REG_Y_CENTER    = 3'd1;
    localparam logic [2:0] REG_X_DEADZONE  = 3'd2;
    localparam logic [2:0] REG_Y_DEADZONE  = 3'd3;
    localparam logic [2:0] REG_DIR_ENABLE  = 3'd4;

    localparam int CENTRE_RESET   = 2048;
    localparam int DEADZONE_RESET = 200;

    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [2:0] {
        K_LOW,
        K_HIGH,
        K_DEAD,
        K_MAP,
        K_EMPTY
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        logic                in_dz;
        logic [1:0]          dir;
        logic                recenter;
    } axis_res_t;

endpackage

[rtl/joystick_axis_conditioner.sv]
// Joystick axis conditioner.
//
// The input stream (s_tvalid, s_tready, s_tdata) carries one X and one Y
// converter sample per transaction. The output stream (m_tvalid, m_tready,
// m_tdata) returns one result per input: mapped positions, deadzone flags,
// latched directions and recentre requests for both axes. Centres, deadzones
// and the direction enable are written through the cfg_we / cfg_index / cfg_wdata
// port, which the user may only do while the block is idle; it is not enforced.
//
// Each item is evaluated for both axes in the same cycle, then the linear
// map of X and then of Y runs through a single shared restoring divider
// that produces one quotient bit per cycle. A result appears when the
// block returns to idle, and s_tready rises again with it, so no new item
// is taken while one is still in progress, chiefly in the two divisions.
// Reset clears the range marks, stability counters and direction latches
// and loads the register defaults. If the receiver stalls, the result is
// held in the output register and the next item is taken and worked on,
// but it is not committed until the previous result has been taken.
module joystick_axis_conditioner
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // x_sample, y_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // x_position, y_position, x_in_deadzone, y_in_deadzone, x_direction,
    // y_direction, x_recenter_request, y_recenter_request
    output logic [OUT_DATA_BITS-1:0]                m_tdata,
    input  logic                                    cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  logic [SAMPLE_BITS-1:0]                  cfg_wdata
);

    localparam int NW = SAMPLE_BITS + QUOT_BITS;

    state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] x_centre_reg, y_centre_reg;
    logic [SAMPLE_BITS-1:0] x_dz_reg, y_dz_reg;
    logic                   dir_en_reg;

    logic [SAMPLE_BITS-1:0] xs_reg, ys_reg;
    logic [QUOT_BITS-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg, m_data_next;

    logic                   accept;
    logic                   eval;
    logic                   commit;
    logic                   div_start;
    logic                   div_done;
    logic [QUOT_BITS-1:0]   div_quot;
    logic [NW-1:0]          div_num;
    logic [SAMPLE_BITS-1:0] div_den;
    logic [NW-1:0]          x_num, y_num;
    logic [SAMPLE_BITS-1:0] x_den, y_den;
    axis_res_t              x_res, y_res;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_centre_reg <= SAMPLE_BITS'(CENTRE_RESET);
            y_centre_reg <= SAMPLE_BITS'(CENTRE_RESET);
            x_dz_reg     <= SAMPLE_BITS'(DEADZONE_RESET);
            y_dz_reg     <= SAMPLE_BITS'(DEADZONE_RESET);
            dir_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_CENTER:   x_centre_reg <= cfg_wdata;
                REG_Y_CENTER:   y_centre_reg <= cfg_wdata;
                REG_X_DEADZONE: x_dz_reg     <= cfg_wdata;
                REG_Y_DEADZONE: y_dz_reg     <= cfg_wdata;
                REG_DIR_ENABLE: dir_en_reg   <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        eval         = 1'b0;
        commit       = 1'b0;
        div_start    = 1'b0;
        div_num      = x_num;
        div_den      = x_den;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                eval       = 1'b1;
                state_next = ST_DIVX_GO;
            end
            ST_DIVX_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    qx_next    = div_quot;
                    state_next = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                div_start  = 1'b1;
                div_num    = y_num;
                div_den    = y_den;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    qy_next    = div_quot;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    commit       = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, y_res.recenter, x_res.recenter,
                                    y_res.dir, x_res.dir, y_res.in_dz, x_res.in_dz,
                                    y_res.pos, x_res.pos};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xs_reg <= s_tdata[SAMPLE_BITS-1:0];
            ys_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        m_data_reg <= m_data_next;
    end

    jac_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .eval     (eval),
        .commit   (commit),
        .dir_en   (dir_en_reg),
        .sample   (xs_reg),
        .centre   (x_centre_reg),
        .deadzone (x_dz_reg),
        .quot     (qx_reg),
        .res      (x_res),
        .num      (x_num),
        .den      (x_den)
    );

    jac_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .eval     (eval),
        .commit   (commit),
        .dir_en   (dir_en_reg),
        .sample   (ys_reg),
        .centre   (y_centre_reg),
        .deadzone (y_dz_reg),
        .quot     (qy_reg),
        .res      (y_res),
        .num      (y_num),
        .den      (y_den)
    );

    jac_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/jac_divider.sv]
module jac_divider
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [SAMPLE_BITS+QUOT_BITS-1:0] num,
    input  logic [SAMPLE_BITS-1:0]         den,
    output logic                           done,
    output logic [QUOT_BITS-1:0]           quot
);

    localparam int NW = SAMPLE_BITS + QUOT_BITS;

    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        dsh_reg, dsh_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NW'(den) << (QUOT_BITS - 1);
            q_next    = '0;
            cnt_next  = QCNT_BITS'(QUOT_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QUOT_BITS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/jac_axis.sv]
module jac_axis
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             eval,
    input  logic                             commit,
    input  logic                             dir_en,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic [SAMPLE_BITS-1:0]           centre,
    input  logic [SAMPLE_BITS-1:0]           deadzone,
    input  logic [QUOT_BITS-1:0]             quot,
    output axis_res_t                        res,
    output logic [SAMPLE_BITS+QUOT_BITS-1:0] num,
    output logic [SAMPLE_BITS-1:0]           den
);

    localparam int NW = SAMPLE_BITS + QUOT_BITS;

    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [SAMPLE_BITS-1:0] high_reg, high_next;
    logic [SAMPLE_BITS-1:0] last_reg;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [1:0]             dir_reg, dir_next;
    kind_t                  kind_reg, kind_next;
    logic                   rec_reg, rec_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [SAMPLE_BITS-1:0] den_reg, den_next;

    logic [SAMPLE_BITS-1:0] offset;
    logic [SAMPLE_BITS-1:0] step;
    logic [SAMPLE_BITS-1:0] span;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [POS_BITS-1:0]    pos;

    assign offset    = (sample >= centre) ? (sample - centre) : (centre - sample);
    assign step      = (sample >= last_reg) ? (sample - last_reg) : (last_reg - sample);
    assign span      = sample - low_reg;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        rec_next   = rec_reg;
        // 98 * span by shifts: 64 + 32 + 2.
        num_next   = (NW'(span) << 6) + (NW'(span) << 5) + (NW'(span) << 1);
        den_next   = high_reg - low_reg;
        if (eval)
        begin
            rec_next = 1'b0;
            if (sample < low_reg)
            begin
                low_next  = sample;
                kind_next = K_LOW;
            end
            else if (sample > high_reg)
            begin
                high_next = sample;
                kind_next = K_HIGH;
            end
            else if (offset < deadzone)
            begin
                kind_next = K_DEAD;
                if (step < SAMPLE_BITS'(STABLE_STEP))
                begin
                    if (count_inc > STABLE_LIMIT)
                    begin
                        rec_next   = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    count_next = '0;
                end
            end
            else if (high_reg > low_reg)
            begin
                kind_next = K_MAP;
            end
            else
            begin
                kind_next = K_EMPTY;
            end
        end
    end

    always_comb
    begin
        case (kind_reg)
            K_LOW:   pos = POS_LOW;
            K_HIGH:  pos = POS_HIGH;
            K_MAP:   pos = quot + 1'b1;
            default: pos = POS_CENTRE;
        endcase
    end

    // The latch picks a side once and keeps it until the position returns
    // to the middle band; while dir_en is low it holds its side.
    always_comb
    begin
        dir_next = dir_reg;
        if (dir_en)
        begin
            if (pos < POS_DIR_LOW)
            begin
                if (dir_reg == DIR_NONE)
                begin
                    dir_next = DIR_NEG;
                end
            end
            else if (pos > POS_DIR_HIGH)
            begin
                if (dir_reg == DIR_NONE)
                begin
                    dir_next = DIR_POS;
                end
            end
            else
            begin
                dir_next = DIR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '1;
            high_reg  <= '0;
            last_reg  <= '0;
            count_reg <= '0;
            dir_reg   <= DIR_NONE;
            kind_reg  <= K_EMPTY;
            rec_reg   <= 1'b0;
        end
        else
        begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            rec_reg   <= rec_next;
            if (commit)
            begin
                last_reg <= sample;
                dir_reg  <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign num          = num_reg;
    assign den          = den_reg;
    assign res.pos      = pos;
    assign res.in_dz    = (kind_reg == K_DEAD);
    assign res.dir      = dir_next;
    assign res.recenter = rec_reg;

endmodule

[rtl/jac_checker.sv]
module jac_checker
    import jac_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] >= POS_LOW && m_tdata[6:0] <= POS_HIGH
                  && m_tdata[13:7] >= POS_LOW && m_tdata[13:7] <= POS_HIGH)
        else $error("mapped position out of range");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:16] != 2'b11 && m_tdata[19:18] != 2'b11)
        else $error("invalid direction code");

    // A recentre request only comes from a sample at rest in the deadzone.
    a_recentre_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[20] || (m_tdata[14] && m_tdata[6:0] == POS_CENTRE))
                  && (!m_tdata[21] || (m_tdata[15] && m_tdata[13:7] == POS_CENTRE)))
        else $error("recentre request outside the deadzone");

endmodule

bind joystick_axis_conditioner jac_checker u_jac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import jac_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int S_DATA_BITS  = ((2*SAMPLE_BITS+7)/8)*8;
    // Extra cycles to wait after the last result has come out.
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        axis_res_t x;
        axis_res_t y;
    } reading_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // x_sample, y_sample
    logic [S_DATA_BITS-1:0]     s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // x_position, y_position, x_in_deadzone, y_in_deadzone, x_direction,
    // y_direction, x_recenter_request, y_recenter_request
    logic [OUT_DATA_BITS-1:0]   m_tdata;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [SAMPLE_BITS-1:0]     cfg_wdata = '0;

    // Predicted copy of the block's registers and per-axis state.
    logic [SAMPLE_BITS-1:0]     centre_reg [2];
    logic [SAMPLE_BITS-1:0]     deadzone_reg [2];
    logic                       dir_enable_reg;
    logic [SAMPLE_BITS-1:0]     low_mark [2];
    logic [SAMPLE_BITS-1:0]     high_mark [2];
    logic [SAMPLE_BITS-1:0]     last_sample [2];
    logic [COUNT_BITS-1:0]      stable_count [2];
    logic [1:0]                 dir_latch [2];

    reading_t                   predicted_readings [$];
    int                         mismatch_count = 0;
    int                         tx_idle_pct = 0;
    int                         rx_idle_pct = 0;
    int                         hold_asks = 0;

    joystick_axis_conditioner #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Works out one axis of a reading and updates that axis's state.
    function automatic axis_res_t map_axis(input int a, input logic [SAMPLE_BITS-1:0] s);
        axis_res_t r;
        int sv, cv, lo, hi, off, step, pos;
        sv = int'(s);
        cv = int'(centre_reg[a]);
        lo = int'(low_mark[a]);
        hi = int'(high_mark[a]);
        off = (sv >= cv) ? sv - cv : cv - sv;
        step = (sv >= int'(last_sample[a])) ? sv - int'(last_sample[a])
                                            : int'(last_sample[a]) - sv;
        r.in_dz = 1'b0;
        r.recenter = 1'b0;
        if (sv < lo)
        begin
            low_mark[a] = s;
            pos = int'(POS_LOW);
        end
        else if (sv > hi)
        begin
            high_mark[a] = s;
            pos = int'(POS_HIGH);
        end
        else if (off < int'(deadzone_reg[a]))
        begin
            r.in_dz = 1'b1;
            pos = int'(POS_CENTRE);
            if (step < STABLE_STEP)
            begin
                stable_count[a] = stable_count[a] + 1'b1;
                if (stable_count[a] > STABLE_LIMIT)
                begin
                    r.recenter = 1'b1;
                    stable_count[a] = '0;
                end
            end
            else
            begin
                stable_count[a] = '0;
            end
        end
        else if (hi > lo)
        begin
            pos = (sv - lo) * int'(POS_HIGH - POS_LOW) / (hi - lo) + 1;
        end
        else
        begin
            pos = int'(POS_CENTRE);
        end

        if (dir_enable_reg)
        begin
            if (pos < int'(POS_DIR_LOW))
            begin
                if (dir_latch[a] == DIR_NONE)
                    dir_latch[a] = DIR_NEG;
            end
            else if (pos > int'(POS_DIR_HIGH))
            begin
                if (dir_latch[a] == DIR_NONE)
                    dir_latch[a] = DIR_POS;
            end
            else
            begin
                dir_latch[a] = DIR_NONE;
            end
        end
        last_sample[a] = s;
        r.pos = pos[POS_BITS-1:0];
        r.dir = dir_latch[a];
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] jitter(input int base, input int span);
        int v;
        v = base + int'($urandom_range(0, 2*span)) - span;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Noise: anywhere in range, near a deadzone edge, or at an extreme.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int a);
        logic [SAMPLE_BITS-1:0] s;
        case ($urandom_range(3))
            0, 1: s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
            2: s = $urandom_range(1) ? jitter(int'(centre_reg[a]) + int'(deadzone_reg[a]), 2)
                                     : jitter(int'(centre_reg[a]) - int'(deadzone_reg[a]), 2);
            default: s = $urandom_range(1) ? '0 : SAMPLE_MAX[SAMPLE_BITS-1:0];
        endcase
        return s;
    endfunction

    task automatic offer_samples(input logic [SAMPLE_BITS-1:0] xs,
                                 input logic [SAMPLE_BITS-1:0] ys);
        reading_t r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap += int'($urandom_range(1, 8));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ys, xs};
        do
            @(posedge clk);
        while (!s_tready);
        r.x = map_axis(0, xs);
        r.y = map_axis(1, ys);
        predicted_readings.push_back(r);
    endtask

    // Stops offering and lets every outstanding result come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (predicted_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_X_CENTER:   centre_reg[0] = data;
            REG_Y_CENTER:   centre_reg[1] = data;
            REG_X_DEADZONE: deadzone_reg[0] = data;
            REG_Y_DEADZONE: deadzone_reg[1] = data;
            REG_DIR_ENABLE: dir_enable_reg = data[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_dir_enable(input logic en);
        logic [SAMPLE_BITS-1:0] d;
        d = SAMPLE_BITS'($urandom);
        d[0] = en;
        write_reg(REG_DIR_ENABLE, d);
    endtask

    // Resting runs near the centre with small jitter (rest_pct percent of runs)
    // let the stability counter reach a recentre request; the rest is noise.
    task automatic send_stream(input int n, input int rest_pct);
        int sent, run, bx, by;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < rest_pct)
            begin
                run = int'($urandom_range(30, 140));
                bx = int'(jitter(int'(centre_reg[0]), 6));
                by = int'(jitter(int'(centre_reg[1]), 6));
                for (int k = 0; k < run && sent < n; k++)
                begin
                    if ($urandom_range(99) < 2)
                        offer_samples(jitter(bx, 40), jitter(by, 40));
                    else
                        offer_samples(jitter(bx, 4), jitter(by, 4));
                    sent++;
                end
            end
            else
            begin
                run = int'($urandom_range(1, 12));
                for (int k = 0; k < run && sent < n; k++)
                begin
                    offer_samples(pick_sample(0), pick_sample(1));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed();
        // Empty range, then both extremes to open the full range.
        offer_samples(12'd0, 12'd4095);
        offer_samples(12'd0, 12'd4095);
        offer_samples(12'd4095, 12'd0);
        // Deadzone with a large and then a small step from the last sample.
        offer_samples(12'd2048, 12'd2048);
        offer_samples(12'd2050, 12'd2045);
        // Latching, then the opposite side while latched, then clearing.
        offer_samples(12'd1000, 12'd3500);
        offer_samples(12'd3900, 12'd100);
        offer_samples(12'd2400, 12'd1600);
        // Just outside and just inside the deadzone edges.
        offer_samples(12'd1847, 12'd2247);
        offer_samples(12'd1848, 12'd1849);
        offer_samples(12'd2248, 12'd1848);
        // Positions 24 and 76 latch; 25 and 75 clear.
        offer_samples(12'd1002, 12'd3134);
        offer_samples(12'd1003, 12'd3093);
        offer_samples(12'd3134, 12'd1002);
        offer_samples(12'd3093, 12'd1003);
        // Linear map at the very ends of the range gives 99 and 1.
        offer_samples(12'd4095, 12'd0);
        offer_samples(12'd0, 12'd4095);
        wait_idle();
        // A deadzone of zero is never entered.
        write_reg(REG_X_DEADZONE, 12'd0);
        offer_samples(12'd2048, 12'd2048);
        wait_idle();
        // With direction latching off the latches hold.
        write_dir_enable(1'b0);
        offer_samples(12'd100, 12'd4000);
        offer_samples(12'd2000, 12'd2100);
        wait_idle();
        write_reg(REG_X_DEADZONE, DEADZONE_RESET[SAMPLE_BITS-1:0]);
        write_dir_enable(1'b1);
        offer_samples(12'd100, 12'd4000);
    endtask

    task automatic test_resting();
        send_stream(150, 80);
    endtask

    task automatic test_extreme_registers();
        wait_idle();
        write_reg(REG_X_CENTER, 12'd0);
        write_reg(REG_Y_CENTER, 12'd4095);
        write_reg(REG_X_DEADZONE, 12'd0);
        write_reg(REG_Y_DEADZONE, 12'd4095);
        write_dir_enable(1'b0);
        // Indexes past the register list must be ignored.
        for (int idx = REG_DIR_ENABLE + 1; idx < (1 << CFG_INDEX_BITS); idx++)
            write_reg(idx[CFG_INDEX_BITS-1:0], SAMPLE_BITS'($urandom));
        send_stream(50, 50);
        wait_idle();
        write_reg(REG_X_CENTER, 12'd4095);
        write_reg(REG_Y_CENTER, 12'd0);
        write_reg(REG_X_DEADZONE, 12'd4095);
        write_reg(REG_Y_DEADZONE, 12'd0);
        write_dir_enable(1'b1);
        send_stream(50, 50);
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the block fills up and stops taking transactions.
    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_X_CENTER, 12'd2048);
        write_reg(REG_Y_CENTER, 12'd2048);
        write_reg(REG_X_DEADZONE, 12'd200);
        write_reg(REG_Y_DEADZONE, 12'd200);
        hold_asks++;
        send_stream(30, 30);
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 4; round++)
        begin
            wait_idle();
            write_reg(REG_X_CENTER, SAMPLE_BITS'($urandom));
            write_reg(REG_Y_CENTER, SAMPLE_BITS'($urandom));
            write_reg(REG_X_DEADZONE, SAMPLE_BITS'($urandom_range(3) == 0 ? $urandom
                                                          : $urandom_range(0, 600)));
            write_reg(REG_Y_DEADZONE, SAMPLE_BITS'($urandom_range(3) == 0 ? $urandom
                                                          : $urandom_range(0, 600)));
            write_dir_enable(1'($urandom_range(1)));
            send_stream(40, 60);
        end
    endtask

    initial
    begin
        centre_reg[0] = CENTRE_RESET[SAMPLE_BITS-1:0];
        centre_reg[1] = CENTRE_RESET[SAMPLE_BITS-1:0];
        deadzone_reg[0] = DEADZONE_RESET[SAMPLE_BITS-1:0];
        deadzone_reg[1] = DEADZONE_RESET[SAMPLE_BITS-1:0];
        dir_enable_reg = 1'b1;
        for (int a = 0; a < 2; a++)
        begin
            low_mark[a] = SAMPLE_MAX[SAMPLE_BITS-1:0];
            high_mark[a] = '0;
            last_sample[a] = '0;
            stable_count[a] = '0;
            dir_latch[a] = DIR_NONE;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 10;
        rx_idle_pct = 47;
        test_directed();
        test_resting();

        tx_idle_pct = 47;
        rx_idle_pct = 10;
        test_extreme_registers();
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_settings();

        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != seen)
            begin
                seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_readings.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = predicted_readings.pop_front();
                check_field("x_position", int'(want.x.pos), int'(m_tdata[6:0]));
                check_field("y_position", int'(want.y.pos), int'(m_tdata[13:7]));
                check_field("x_in_deadzone", int'(want.x.in_dz), int'(m_tdata[14]));
                check_field("y_in_deadzone", int'(want.y.in_dz), int'(m_tdata[15]));
                check_field("x_direction", int'(want.x.dir), int'(m_tdata[17:16]));
                check_field("y_direction", int'(want.y.dir), int'(m_tdata[19:18]));
                check_field("x_recenter_request", int'(want.x.recenter), int'(m_tdata[20]));
                check_field("y_recenter_request", int'(want.y.recenter), int'(m_tdata[21]));
                check_field("padding", 0, int'(m_tdata[OUT_DATA_BITS-1:22]));
            end
        end
    end

endmodule

[joystick_axis_conditioner.f]
rtl/jac_pkg.sv
rtl/jac_divider.sv
rtl/jac_axis.sv
rtl/joystick_axis_conditioner.sv
rtl/jac_checker.sv
test/tb_top.sv
